/* rtl/core/ikhm_pkg.sv */
// Package for the integer key hash map: fixed field widths, hash constant,
// request codes, state encodings and the result record. No dependencies.
package ikhm_pkg;

  localparam int KEY_W     = 32;
  localparam int DATA_W    = 32;
  localparam int BCNT_W    = 9;
  localparam int COUNT_W   = 11;
  localparam int DIV_STEPS = 8;   // remainder bits folded in per cycle
  localparam int PROD_W    = 64;

  localparam logic [KEY_W-1:0]   HASH_MULT = 32'd2654435761;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_SUB,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_EVAL
  } back_state_t;

  typedef struct packed {
    logic               hit;
    logic [DATA_W-1:0]  value_out;
    logic               bucket_full;
    logic [COUNT_W-1:0] entry_count;
  } result_t;

endpackage

/* rtl/core/ikhm_fifo.sv */
// Two-entry first-in first-out queue for a packed payload.
// Used between the front and back parts and on the result side.
module ikhm_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* rtl/core/ikhm_front.sv */
// Front part of the hash map: takes a request, forms the 64-bit
// multiplicative hash and reduces it modulo the bucket count.
// Depends on ikhm_pkg.
module ikhm_front #(
  parameter int VW = 32,
  parameter int BW = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        busy,
  input  logic                        req_type,
  input  logic [ikhm_pkg::KEY_W-1:0]  key,
  input  logic [VW-1:0]               value,
  input  logic [ikhm_pkg::BCNT_W-1:0] modulus,
  output logic                        q_push,
  input  logic                        q_full,
  output logic [1+ikhm_pkg::KEY_W+VW+BW-1:0] q_data
);
  import ikhm_pkg::*;

  front_state_t state_r, state_nxt;
  logic [2:0]        step_r, step_nxt;
  logic              typ_r;
  logic [KEY_W-1:0]  key_r;
  logic [VW-1:0]     val_r;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [BCNT_W-1:0] rem_r, rem_nxt;
  logic [PROD_W-1:0] mul_full;
  logic [BCNT_W:0]   trial;
  logic [BW+BCNT_W-1:0] idx_ext;

  // Low half of the product only sees the unsigned key; a negative key
  // subtracts the constant shifted up by 32, modulo 2^64.
  assign mul_full = key_r * HASH_MULT;
  assign idx_ext  = {{BW{1'b0}}, rem_r};
  assign q_data   = {typ_r, key_r, val_r, idx_ext[BW-1:0]};
  assign busy     = (state_r != F_IDLE);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    q_push    = 1'b0;
    trial     = '0;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        prod_nxt  = mul_full;
        state_nxt = F_SUB;
      end
      F_SUB: begin
        prod_nxt  = prod_r - (key_r[KEY_W-1] ? {HASH_MULT, 32'd0} : '0);
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = F_DIV;
      end
      F_DIV: begin
        for (int i = 0; i < DIV_STEPS; i++) begin
          trial = {rem_nxt, prod_r[PROD_W-1-i]};
          if (trial >= {1'b0, modulus}) begin
            trial = trial - {1'b0, modulus};
          end
          rem_nxt = trial[BCNT_W-1:0];
        end
        prod_nxt = prod_r << DIV_STEPS;
        step_nxt = step_r + 3'd1;
        if (step_r == 3'(PROD_W / DIV_STEPS - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        q_push = 1'b1;
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    if (state_r == F_IDLE && in_valid) begin
      typ_r <= req_type;
      key_r <= key;
      val_r <= value;
    end
  end

endmodule

/* rtl/core/ikhm_back.sv */
// Back part of the hash map: bucket storage, clearing pass after reset,
// read of one bucket row per request, written back when an insert is stored,
// and the entry count. Depends on ikhm_pkg.
module ikhm_back #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4,
  parameter int VW      = 32,
  parameter int BW      = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  output logic                       clearing,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  logic [1+ikhm_pkg::KEY_W+VW+BW-1:0] q_data,
  output logic                       r_push,
  input  logic                       r_full,
  output ikhm_pkg::result_t          r_data
);
  import ikhm_pkg::*;

  localparam int WIW = (WAYS > 1) ? $clog2(WAYS) : 1;

  back_state_t state_r, state_nxt;
  logic [BW-1:0]      clr_r, clr_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic               typ_r;
  logic [KEY_W-1:0]   key_r;
  logic [VW-1:0]      val_r;
  logic [BW-1:0]      idx_r;

  logic [WAYS-1:0]       vmem_r [BUCKETS];
  logic [WAYS*KEY_W-1:0] kmem_r [BUCKETS];
  logic [WAYS*VW-1:0]    dmem_r [BUCKETS];
  logic [WAYS-1:0]       vrd_r;
  logic [WAYS*KEY_W-1:0] krd_r;
  logic [WAYS*VW-1:0]    drd_r;

  logic                  found, has_free, row_we, vm_we;
  logic [WIW-1:0]        fidx, free_idx;
  logic [WAYS-1:0]       vrow_new, vm_wdata;
  logic [WAYS*KEY_W-1:0] krow_new;
  logic [WAYS*VW-1:0]    drow_new;
  logic [BW-1:0]         vm_addr;
  logic [VW+DATA_W-1:0]  vout_ext;

  assign clearing = (state_r == B_CLEAR);
  assign vm_addr  = clearing ? clr_r : idx_r;
  assign vm_wdata = clearing ? '0 : vrow_new;

  // Way search over the row read out of storage: first match, first free.
  always_comb begin
    found    = 1'b0;
    has_free = 1'b0;
    fidx     = '0;
    free_idx = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (vrd_r[w] && krd_r[w*KEY_W +: KEY_W] == key_r && !found) begin
        found = 1'b1;
        fidx  = WIW'(w);
      end
      if (!vrd_r[w] && !has_free) begin
        has_free = 1'b1;
        free_idx = WIW'(w);
      end
    end
  end

  always_comb begin
    vrow_new = vrd_r;
    krow_new = krd_r;
    drow_new = drd_r;
    if (found) begin
      drow_new[fidx*VW +: VW] = val_r;
    end else begin
      vrow_new[free_idx]            = 1'b1;
      krow_new[free_idx*KEY_W +: KEY_W] = key_r;
      drow_new[free_idx*VW +: VW]   = val_r;
    end
  end

  assign vout_ext = {{DATA_W{1'b0}}, drd_r[fidx*VW +: VW]};

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    count_nxt = count_r;
    q_pop     = 1'b0;
    r_push    = 1'b0;
    row_we    = 1'b0;
    vm_we     = 1'b0;
    r_data    = '0;
    case (state_r)
      B_CLEAR: begin
        vm_we   = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BW'(BUCKETS - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = B_READ;
        end
      end
      B_READ: begin
        state_nxt = B_EVAL;
      end
      B_EVAL: begin
        if (typ_r == REQ_INSERT) begin
          r_data.hit         = found;
          r_data.bucket_full = !found && !has_free;
          if (!found && has_free && count_r != COUNT_MAX) begin
            count_nxt = count_r + 1'b1;
          end
        end else begin
          r_data.hit = found;
          if (found) begin
            r_data.value_out = vout_ext[DATA_W-1:0];
          end
        end
        r_data.entry_count = count_nxt;
        if (!r_full) begin
          r_push    = 1'b1;
          row_we    = (typ_r == REQ_INSERT) && (found || has_free);
          vm_we     = row_we;
          state_nxt = B_IDLE;
        end else begin
          count_nxt = count_r;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLEAR;
      clr_r   <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      {typ_r, key_r, val_r, idx_r} <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (vm_we) begin
      vmem_r[vm_addr] <= vm_wdata;
    end
    if (row_we) begin
      kmem_r[idx_r] <= krow_new;
      dmem_r[idx_r] <= drow_new;
    end
    vrd_r <= vmem_r[idx_r];
    krd_r <= kmem_r[idx_r];
    drd_r <= dmem_r[idx_r];
  end

endmodule

/* rtl/core/int_key_hash_map_top.sv */
// Top level of the integer key hash map: configuration register, front
// hashing part, request queue, back storage part and result queue.
// Depends on ikhm_pkg, ikhm_fifo, ikhm_front and ikhm_back.
//
//   channel   direction  handshake           payload
//   in_       input      in_push / in_full   in_req_type, in_key, in_value_in
//   out_      output     out_pop / out_empty out_hit, out_value_out,
//                                            out_bucket_full, out_entry_count
//   cfg_      input      cfg_we              cfg_wdata (bucket count)
//
// A request passes through the front part in order: it is captured, then the
// 32 by 32 multiply is done, then the sign correction of the product, then
// the remainder (eight quotient bits a cycle), and last it is moved into the
// request queue; the front takes no new request until then. The back part
// pops a request, reads the bucket row, then does the way search and row write;
// it overlaps with the front, so the remainder loop sets the sustained rate.
// After reset the back part clears the valid bits of every bucket, one bucket
// a cycle; in_full stays high during that pass.
// A full result queue stalls the back part, and a full request queue then
// stalls the front part, without losing any transfer.
module int_key_hash_map_top #(
  parameter int BUCKETS     = 256,
  parameter int WAYS        = 4,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_req_type,
  input  logic signed [ikhm_pkg::KEY_W-1:0] in_key,
  input  logic [ikhm_pkg::DATA_W-1:0]    in_value_in,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic                           out_hit,
  output logic [ikhm_pkg::DATA_W-1:0]    out_value_out,
  output logic                           out_bucket_full,
  output logic [ikhm_pkg::COUNT_W-1:0]   out_entry_count,
  input  logic                           cfg_we,
  input  logic [ikhm_pkg::BCNT_W-1:0]    cfg_wdata
);
  import ikhm_pkg::*;

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int QW = 1 + KEY_W + VALUE_WIDTH + BW;

  logic [BCNT_W-1:0] bcount_r;
  logic [BCNT_W-1:0] modulus;
  logic              front_busy, clearing, in_take;
  logic [VALUE_WIDTH+DATA_W-1:0] vin_ext;
  logic              fq_push, fq_full, fq_pop, fq_empty;
  logic [QW-1:0]     fq_wdata, fq_rdata;
  logic              rq_push, rq_full;
  result_t           rq_wdata, rq_rdata;

  // The bucket count register; zero acts as one, and values past the
  // table size act as the table size.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcount_r <= 9'd256;
    end else if (cfg_we) begin
      bcount_r <= cfg_wdata;
    end
  end

  always_comb begin
    modulus = bcount_r;
    if ({8'd0, bcount_r} > 17'(BUCKETS)) begin
      modulus = BCNT_W'(BUCKETS);
    end
    if (bcount_r == '0) begin
      modulus = 9'd1;
    end
  end

  assign in_full = front_busy || clearing;
  assign in_take = in_push && !in_full;
  assign vin_ext = {{VALUE_WIDTH{1'b0}}, in_value_in};

  ikhm_front #(
    .VW (VALUE_WIDTH),
    .BW (BW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_take),
    .busy     (front_busy),
    .req_type (in_req_type),
    .key      (in_key),
    .value    (vin_ext[VALUE_WIDTH-1:0]),
    .modulus  (modulus),
    .q_push   (fq_push),
    .q_full   (fq_full),
    .q_data   (fq_wdata)
  );

  ikhm_fifo #(
    .WIDTH (QW)
  ) u_req_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata (fq_wdata),
    .full  (fq_full),
    .pop   (fq_pop),
    .rdata (fq_rdata),
    .empty (fq_empty)
  );

  ikhm_back #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS),
    .VW      (VALUE_WIDTH),
    .BW      (BW)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .clearing (clearing),
    .q_empty  (fq_empty),
    .q_pop    (fq_pop),
    .q_data   (fq_rdata),
    .r_push   (rq_push),
    .r_full   (rq_full),
    .r_data   (rq_wdata)
  );

  ikhm_fifo #(
    .WIDTH ($bits(result_t))
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .wdata (rq_wdata),
    .full  (rq_full),
    .pop   (out_pop),
    .rdata (rq_rdata),
    .empty (out_empty)
  );

  assign out_hit         = rq_rdata.hit;
  assign out_value_out   = rq_rdata.value_out;
  assign out_bucket_full = rq_rdata.bucket_full;
  assign out_entry_count = rq_rdata.entry_count;

endmodule
